>>> sv/nll_pkg.sv
// Shared types, constants and helpers for the nonlinear ladder low-pass.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package nll_pkg;

    localparam int STAGE_COUNT   = 4;
    localparam int TANH_DEPTH    = 256;
    localparam int SAMPLE_W      = 16;
    localparam int STAGE_W       = 18;      // Q2.16, |v| <= 1.0
    localparam int ARG_W         = 24;      // stage argument, Q16 signed
    localparam int D_W           = 26;      // denominator, unsigned Q12
    localparam int MUL_A_W       = 27;
    localparam int MUL_B_W       = 20;
    localparam int PROD_W        = MUL_A_W + MUL_B_W;
    localparam int DIVN_W        = 34;
    localparam int Q_W           = 23;      // quotient bits that can be set
    localparam int ROM_W         = 17;
    localparam int SPAN_SHIFT    = 19;      // tanh span is 0 .. 8.0
    localparam int G_MAX         = 40960;
    localparam int K_MAX         = 65536;
    localparam int ONE_Q12       = 4096;
    localparam int ONE_Q16       = 65536;
    localparam int CUTOFF_RESET  = 410;

    localparam int REG_CUTOFF    = 0;
    localparam int REG_FEEDBACK  = 1;
    localparam int REG_ENABLE    = 2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_D_MUL,
        ST_D_ACC,
        ST_K_MUL,
        ST_K_ACC,
        ST_DIV,
        ST_S_MUL,
        ST_S_ARG,
        ST_S_IDX,
        ST_S_LO,
        ST_S_HI,
        ST_S_INT,
        ST_DONE
    } nll_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // Arithmetic right shift, rounding half away from zero.
    function automatic logic signed [PROD_W:0] shr_round(
        input logic signed [PROD_W:0] v,
        input int unsigned            s
    );
        logic [PROD_W:0] half;
        logic [PROD_W:0] mag;
        half = (PROD_W + 1)'(1) << (s - 1);
        mag  = v[PROD_W] ? (PROD_W + 1)'(-v) : (PROD_W + 1)'(v);
        mag  = (mag + half) >> s;
        return v[PROD_W] ? -$signed(mag) : $signed(mag);
    endfunction

endpackage

`default_nettype wire

>>> sv/nll_mul.sv
// Shared signed multiplier with a registered product.
// Depends on nll_pkg for operand widths.
`timescale 1ns / 1ps
`default_nettype none

module nll_mul (
    input  wire logic                                clk,
    input  wire logic signed [nll_pkg::MUL_A_W-1:0]  mul_a,
    input  wire logic signed [nll_pkg::MUL_B_W-1:0]  mul_b,
    output logic signed      [nll_pkg::PROD_W-1:0]   prod_reg
);
    import nll_pkg::*;

    logic signed [PROD_W-1:0] prod_next;

    assign prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

endmodule

`default_nettype wire

>>> sv/nll_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on nll_pkg for widths and the status struct.
`timescale 1ns / 1ps
`default_nettype none

module nll_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [nll_pkg::DIVN_W-1:0]    dividend,
    input  wire logic [nll_pkg::D_W-1:0]       divisor,
    output logic      [nll_pkg::DIVN_W-1:0]    quotient,
    output nll_pkg::div_stat_t                 stat
);
    import nll_pkg::*;

    localparam int CW = $clog2(DIVN_W + 1);

    logic [DIVN_W-1:0] quo_reg, quo_next;
    logic [D_W-1:0]    rem_reg, rem_next;
    logic [D_W-1:0]    den_reg, den_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [D_W:0]      rem_sh;
    logic [D_W+1:0]    diff;

    assign rem_sh = {rem_reg, quo_reg[DIVN_W-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, den_reg};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
            cnt_next  = CW'(DIVN_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[D_W+1])
            begin
                rem_next = diff[D_W-1:0];
                quo_next = {quo_reg[DIVN_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[D_W-1:0];
                quo_next = {quo_reg[DIVN_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire

>>> sv/nll_tanh_rom.sv
// tanh lookup table (Q16, inputs 0 .. 8.0) with registered read.
// Contents are built at elaboration; depends on nll_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nll_tanh_rom #(
    parameter int TANH_TABLE_DEPTH = nll_pkg::TANH_DEPTH
) (
    input  wire logic                                  clk,
    input  wire logic [$clog2(TANH_TABLE_DEPTH+1)-1:0] addr,
    output logic      [nll_pkg::ROM_W-1:0]             rd_data_reg
);
    import nll_pkg::*;

    typedef logic [ROM_W-1:0] rom_t [0:TANH_TABLE_DEPTH];

    // Shift-subtract quotient, used only while the table is built.
    function automatic logic [63:0] udiv(
        input logic [63:0] n,
        input logic [63:0] d
    );
        logic [64:0] rem;
        logic [63:0] q;
        rem = '0;
        q   = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], n[b]};
            if (rem >= {1'b0, d})
            begin
                rem  = rem - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // tanh(x) = (1 - e^-2x) / (1 + e^-2x), e^-2x from 1/e^(2x/32) raised to 32.
    function automatic rom_t build_rom();
        rom_t              r;
        longint unsigned   z;
        longint unsigned   term;
        longint unsigned   e;
        longint unsigned   w;
        longint unsigned   q30;
        longint unsigned   n;
        for (int i = 0; i <= TANH_TABLE_DEPTH; i++)
        begin
            q30  = 64'd1 << 30;
            z    = udiv(64'(longint'(i) << 29), 64'(TANH_TABLE_DEPTH));
            term = q30;
            e    = q30;
            n    = 1;
            while (term != 0 && n < 64)
            begin
                term = udiv(term * z, n << 30);
                e    = e + term;
                n    = n + 1;
            end
            w = udiv((64'd1 << 60) + (e >> 1), e);
            for (int k = 0; k < 5; k++)
                w = (w * w + (64'd1 << 29)) >> 30;
            r[i] = ROM_W'(udiv((q30 - w) * 65536 + ((q30 + w) >> 1), q30 + w));
        end
        return r;
    endfunction

    localparam rom_t TANH_ROM = build_rom();

    always_ff @(posedge clk)
    begin
        rd_data_reg <= TANH_ROM[addr];
    end

endmodule

`default_nettype wire

>>> sv/nonlinear_ladder_lowpass.sv
// Four-pole nonlinear ladder low-pass: APB registers, sequencer and datapath.
// Depends on nll_pkg, nll_mul, nll_div and nll_tanh_rom.
//
// Usage:
//   Input channel in_valid/in_ready carries sample_in (signed Q15); output
//   channel out_valid/out_ready carries sample_out (signed Q15, saturated).
//   One transfer in gives exactly one transfer out.
//   cutoff_coeff (addr 0x0, Q4.12 g, clamped to 10.0), feedback_gain (addr
//   0x4, Q5.12 k, clamped to 16.0) and filter_enable (addr 0x8); pready is
//   tied high. The user must write them over APB while the block is idle;
//   the block itself does not enforce this.
// Sequencing:
//   Filtering: the work per sample is mostly set by the single shared
//   multiplier (products in turn: denominator 4x, feedback 1x, then per
//   stage the tanh table interpolation, fewer when the stage argument is
//   past the table span), plus the bit-serial divider for the feedback sum.
//   Bypass (filter_enable = 0): straight to done, stage values untouched.
//   in_ready is high only in the idle state. A finished result sits in the
//   output register, so the next sample is accepted while it waits; if the
//   receiver is still stalled when that sample is done, the sequencer holds
//   in its done state until the output register frees up.
// Reset:
//   rst_n (async, active low) clears the four stage values, restores the
//   register defaults (g = 410, k = 0, bypass) and drops out_valid.
`timescale 1ns / 1ps
`default_nettype none

module nonlinear_ladder_lowpass #(
    parameter int TANH_TABLE_DEPTH = nll_pkg::TANH_DEPTH
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // APB configuration port
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [3:0]                           paddr,
    input  wire logic [31:0]                          pwdata,
    output logic      [31:0]                          prdata,
    output logic                                      pready,
    // sample input
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic signed [nll_pkg::SAMPLE_W-1:0]  sample_in,
    // sample output
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic signed [nll_pkg::SAMPLE_W-1:0]       sample_out
);
    import nll_pkg::*;

    localparam int AW = $clog2(TANH_TABLE_DEPTH + 1);
    localparam int CW = $clog2(STAGE_COUNT);
    localparam logic [CW-1:0] LAST_STAGE = CW'(STAGE_COUNT - 1);

    // ---------------- configuration registers ----------------
    logic [15:0] cutoff_coeff_reg;
    logic [16:0] feedback_gain_reg;
    logic        filter_enable_reg;
    logic        cfg_write;
    logic [1:0]  cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cutoff_coeff_reg  <= 16'(CUTOFF_RESET);
            feedback_gain_reg <= '0;
            filter_enable_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            if (cfg_index == 2'(REG_CUTOFF))
                cutoff_coeff_reg <= pwdata[15:0];
            if (cfg_index == 2'(REG_FEEDBACK))
                feedback_gain_reg <= pwdata[16:0];
            if (cfg_index == 2'(REG_ENABLE))
                filter_enable_reg <= pwdata[0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (cfg_index == 2'(REG_CUTOFF))
            prdata = {16'd0, cutoff_coeff_reg};
        else if (cfg_index == 2'(REG_FEEDBACK))
            prdata = {15'd0, feedback_gain_reg};
        else if (cfg_index == 2'(REG_ENABLE))
            prdata = {31'd0, filter_enable_reg};
    end

    // clamped coefficients
    logic [15:0] g_val;
    logic [16:0] k_val;

    assign g_val = (cutoff_coeff_reg > 16'(G_MAX)) ? 16'(G_MAX) : cutoff_coeff_reg;
    assign k_val = (feedback_gain_reg > 17'(K_MAX)) ? 17'(K_MAX) : feedback_gain_reg;

    // ---------------- shared units ----------------
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod_reg;
    logic                      div_start;
    logic [DIVN_W-1:0]         div_dividend;
    logic [DIVN_W-1:0]         div_quotient;
    div_stat_t                 div_stat;
    logic [AW-1:0]             rom_addr;
    logic [ROM_W-1:0]          rom_data;
    logic [D_W-1:0]            d_reg, d_next;

    nll_mul u_mul (
        .clk      (clk),
        .mul_a    (mul_a),
        .mul_b    (mul_b),
        .prod_reg (prod_reg)
    );

    nll_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (d_reg),
        .quotient (div_quotient),
        .stat     (div_stat)
    );

    nll_tanh_rom #(
        .TANH_TABLE_DEPTH (TANH_TABLE_DEPTH)
    ) u_rom (
        .clk         (clk),
        .addr        (rom_addr),
        .rd_data_reg (rom_data)
    );

    // ---------------- sequencer state ----------------
    nll_state_t                state_reg, state_next;
    logic [CW-1:0]             cnt_reg, cnt_next;
    logic                      out_valid_reg, out_valid_next;
    logic signed [STAGE_W-1:0] stage_values_reg [STAGE_COUNT];
    logic signed [STAGE_W-1:0] stage_wr_val;
    logic                      stage_wr;

    // payload
    logic signed [SAMPLE_W-1:0] x_reg, x_next;
    logic signed [ARG_W-1:0]   prev_reg, prev_next;
    logic                      neg_reg, neg_next;
    logic [SPAN_SHIFT-1:0]     f_reg, f_next;
    logic [AW-1:0]             idx_reg, idx_next;
    logic [ROM_W-1:0]          lo_reg, lo_next;
    logic signed [SAMPLE_W-1:0] res_reg, res_next;
    logic signed [SAMPLE_W-1:0] out_reg, out_next;

    // helpers
    logic signed [PROD_W:0]    rnd12;
    logic signed [PROD_W:0]    rnd19;
    logic signed [ARG_W-1:0]   num;
    logic [ARG_W-1:0]          num_mag;
    logic signed [ARG_W-1:0]   arg;
    logic [ARG_W-1:0]          arg_mag;
    logic signed [ARG_W-1:0]   quo_s;
    logic signed [STAGE_W-1:0] interp;
    logic signed [STAGE_W-1:0] y_half;
    logic signed [SAMPLE_W-1:0] y_sat;

    assign rnd12 = shr_round({prod_reg[PROD_W-1], prod_reg}, 12);
    assign rnd19 = shr_round({prod_reg[PROD_W-1], prod_reg}, SPAN_SHIFT);

    // output rounding and saturation of the last stage value
    always_comb
    begin
        if (!stage_wr_val[STAGE_W-1])
            y_half = (stage_wr_val + STAGE_W'(1)) >>> 1;
        else
            y_half = -((-stage_wr_val + STAGE_W'(1)) >>> 1);
        if (y_half > STAGE_W'(32767))
            y_sat = 16'sh7FFF;
        else if (y_half < -STAGE_W'(32768))
            y_sat = -16'sh8000;
        else
            y_sat = y_half[SAMPLE_W-1:0];
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        d_next         = d_reg;
        x_next         = x_reg;
        prev_next      = prev_reg;
        neg_next       = neg_reg;
        f_next         = f_reg;
        idx_next       = idx_reg;
        lo_next        = lo_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        in_ready       = 1'b0;
        mul_a          = '0;
        mul_b          = '0;
        div_start      = 1'b0;
        rom_addr       = idx_reg;
        stage_wr       = 1'b0;
        stage_wr_val   = '0;
        num            = (ARG_W'(x_reg) <<< 1) - $signed(rnd12[ARG_W-1:0]);
        num_mag        = num[ARG_W-1] ? ARG_W'(-num) : ARG_W'(num);
        div_dividend   = DIVN_W'({num_mag, 12'd0}) + DIVN_W'(d_reg >> 1);
        quo_s          = $signed({1'b0, div_quotient[Q_W-1:0]});
        arg            = prev_reg + rnd12[ARG_W-1:0];
        arg_mag        = arg[ARG_W-1] ? ARG_W'(-arg) : ARG_W'(arg);
        interp         = $signed({1'b0, lo_reg}) + rnd19[STAGE_W-1:0];

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    x_next = sample_in;
                    if (filter_enable_reg)
                    begin
                        d_next     = D_W'(ONE_Q12);
                        cnt_next   = '0;
                        state_next = ST_D_MUL;
                    end
                    else
                    begin
                        res_next   = sample_in;
                        state_next = ST_DONE;
                    end
                end
            end
            ST_D_MUL:
            begin
                mul_a      = $signed({1'b0, d_reg});
                mul_b      = $signed({4'd0, g_val});
                state_next = ST_D_ACC;
            end
            ST_D_ACC:
            begin
                d_next = D_W'(ONE_Q12) + rnd12[D_W-1:0];
                if (cnt_reg == LAST_STAGE)
                begin
                    cnt_next   = '0;
                    state_next = ST_K_MUL;
                end
                else
                begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = ST_D_MUL;
                end
            end
            ST_K_MUL:
            begin
                mul_a      = MUL_A_W'(stage_values_reg[STAGE_COUNT-1]);
                mul_b      = $signed({3'd0, k_val});
                state_next = ST_K_ACC;
            end
            ST_K_ACC:
            begin
                div_start  = 1'b1;
                neg_next   = num[ARG_W-1];
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    prev_next  = neg_reg ? -quo_s : quo_s;
                    cnt_next   = '0;
                    state_next = ST_S_MUL;
                end
            end
            ST_S_MUL:
            begin
                mul_a      = MUL_A_W'(stage_values_reg[cnt_reg]);
                mul_b      = $signed({4'd0, g_val});
                state_next = ST_S_ARG;
            end
            ST_S_ARG:
            begin
                neg_next = arg[ARG_W-1];
                if (arg_mag >= ARG_W'(1 << SPAN_SHIFT))
                begin
                    // beyond the table span tanh is taken as exactly +/-1
                    stage_wr     = 1'b1;
                    stage_wr_val = arg[ARG_W-1] ? -STAGE_W'(ONE_Q16) : STAGE_W'(ONE_Q16);
                end
                else
                begin
                    mul_a      = $signed({{(MUL_A_W-SPAN_SHIFT){1'b0}},
                                          arg_mag[SPAN_SHIFT-1:0]});
                    mul_b      = MUL_B_W'(TANH_TABLE_DEPTH);
                    state_next = ST_S_IDX;
                end
            end
            ST_S_IDX:
            begin
                idx_next   = prod_reg[SPAN_SHIFT +: AW];
                rom_addr   = prod_reg[SPAN_SHIFT +: AW];
                f_next     = prod_reg[SPAN_SHIFT-1:0];
                state_next = ST_S_LO;
            end
            ST_S_LO:
            begin
                lo_next    = rom_data;
                rom_addr   = idx_reg + 1'b1;
                state_next = ST_S_HI;
            end
            ST_S_HI:
            begin
                mul_a      = $signed({{(MUL_A_W-SPAN_SHIFT){1'b0}}, f_reg});
                mul_b      = MUL_B_W'($signed({1'b0, rom_data}))
                           - MUL_B_W'($signed({1'b0, lo_reg}));
                state_next = ST_S_INT;
            end
            ST_S_INT:
            begin
                stage_wr     = 1'b1;
                stage_wr_val = neg_reg ? -interp : interp;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // stage result written: feed the next stage or finish the sample
        if (stage_wr)
        begin
            prev_next = ARG_W'(stage_wr_val);
            if (cnt_reg == LAST_STAGE)
            begin
                res_next   = y_sat;
                state_next = ST_DONE;
            end
            else
            begin
                cnt_next   = cnt_reg + 1'b1;
                state_next = ST_S_MUL;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < STAGE_COUNT; i++)
                stage_values_reg[i] <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (stage_wr)
                stage_values_reg[cnt_reg] <= stage_wr_val;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg    <= d_next;
        x_reg    <= x_next;
        prev_reg <= prev_next;
        neg_reg  <= neg_next;
        f_reg    <= f_next;
        idx_reg  <= idx_next;
        lo_reg   <= lo_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = out_reg;

    // ---------------- assertions ----------------
    a_bypass_direct: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !filter_enable_reg) |=> state_reg == ST_DONE)
        else $error("bypass transfer did not go straight to done");

    a_div_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider restarted while busy");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("output loaded outside done state");

    a_stage_range: assert property (@(posedge clk) disable iff (!rst_n)
        stage_wr |-> (stage_wr_val <= STAGE_W'(ONE_Q16))
                     && (stage_wr_val >= -STAGE_W'(ONE_Q16)))
        else $error("stage value outside +/-1.0");

endmodule

`default_nettype wire
